>>> sv/isx_pkg.sv
// isx_pkg: shared types, constants and mask helpers for the independent set expansion unit
// no dependencies; used by every module of the block
package isx_pkg;

   localparam int ROW_W = 64;   // adjacency row and mask width
   localparam int IDX_W = 6;    // node index width
   localparam int CNT_W = 7;    // node count width

   typedef enum logic [1:0] {
      OP_WRITE_ROW = 2'd0,
      OP_SEED      = 2'd1,
      OP_EXPAND    = 2'd2
   } opcode_type;

   // one cycle's access to the row memory
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [ROW_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   // ones on the node bits below the count
   function automatic logic [ROW_W-1:0] limit_mask(input logic [CNT_W-1:0] count);
      logic [ROW_W-1:0] mask;
      if (count >= CNT_W'(ROW_W)) begin
         mask = '1;
      end else begin
         mask = (ROW_W'(1) << count) - ROW_W'(1);
      end
      return mask;
   endfunction

   // ones on the node bits strictly above the node
   function automatic logic [ROW_W-1:0] above_mask(input logic [IDX_W-1:0] node);
      logic [CNT_W-1:0] amount;
      amount = {1'b0, node} + CNT_W'(1);
      return ({ROW_W{1'b1}}) << amount;
   endfunction

endpackage

>>> sv/independent_set_expansion_unit.sv
// independent_set_expansion_unit: top level, request decode, candidate issue and result register
// depends on isx_pkg, isx_row_mem and isx_pick
//
// The unit holds one 64-bit adjacency row per graph node in a single-port-read row memory and
// grows independent sets one node at a time. A row write request gives no result. A seed request
// gives one result, or none if its node lies beyond the node count. An expand request with k
// candidate bits below the node count gives k results, one per cycle while the result channel is
// not stalled; each candidate passes through the work register, the row read and the result register.
// The rate is set by the row memory read port: each result needs one row read, and the read
// for the next candidate is issued in the same cycle as the previous result is registered.
// A new request is taken once every candidate of the current one has been read out of the
// memory; the last result may still sit in the output register at that point. The row memory
// has no reset and no clearing pass, so a row must be written before any request reads it.
// node_count must be written on the csr channel only while the unit is idle; the unit does not
// enforce this. Values of zero count as one and values above MAX_NODES count as MAX_NODES.
module independent_set_expansion_unit #(
   parameter int MAX_NODES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [isx_pkg::IDX_W-1:0]     req_node_index,
   input  logic [isx_pkg::ROW_W-1:0]     req_set_bits,
   input  logic [isx_pkg::ROW_W-1:0]     req_candidate_bits,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [isx_pkg::ROW_W-1:0]     rsp_out_set,
   output logic [isx_pkg::ROW_W-1:0]     rsp_out_candidates,
   output logic                          rsp_last,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [isx_pkg::CNT_W-1:0]     csr_node_count
);

   localparam logic [isx_pkg::CNT_W-1:0] MaxCount = isx_pkg::CNT_W'(MAX_NODES);

   // effective node count and its mask, both kept registered
   logic [isx_pkg::CNT_W-1:0] count_ff, count_in;
   logic [isx_pkg::ROW_W-1:0] lim_ff, lim_in;

   // per-request working state
   logic [isx_pkg::ROW_W-1:0] work_ff, work_in;     // candidates still to read
   logic [isx_pkg::ROW_W-1:0] set_ff, set_in;       // base set
   logic [isx_pkg::ROW_W-1:0] cand_ff, cand_in;     // candidate filter

   // row read in flight
   logic                      rd_ff, rd_in;
   logic [isx_pkg::IDX_W-1:0] node_ff, node_in;
   logic                      last_ff, last_in;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic [isx_pkg::ROW_W-1:0] out_set_ff, out_set_in;
   logic [isx_pkg::ROW_W-1:0] out_cand_ff, out_cand_in;
   logic                      out_last_ff, out_last_in;

   logic                      busy;
   logic                      req_take;
   logic                      csr_take;
   logic                      load;
   logic                      issue;
   logic [isx_pkg::IDX_W-1:0] pick_idx;
   logic [isx_pkg::ROW_W-1:0] work_rest;
   logic [isx_pkg::ROW_W-1:0] rd_data;
   isx_pkg::mem_req_type      mem_req;

   // ---------------------------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------------------------

   // busy while candidates remain or a row read is outstanding
   assign busy      = (work_ff != '0) || rd_ff;
   assign req_stall = busy;
   assign req_take  = req_valid && !busy;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   // a returning row is registered when the result slot is free or draining
   assign load  = rd_ff && (!out_valid_ff || !rsp_stall);
   // the next read may go out as soon as the previous one is being consumed
   assign issue = (work_ff != '0) && (!rd_ff || load);

   // ---------------------------------------------------------------------------------------
   // candidate pick and row memory
   // ---------------------------------------------------------------------------------------

   isx_pick u_pick (
      .work      (work_ff),
      .pick_idx  (pick_idx),
      .work_rest (work_rest)
   );

   always_comb begin
      mem_req         = '0;
      mem_req.rd_en   = issue;
      mem_req.rd_addr = pick_idx;
      mem_req.wr_addr = req_node_index;
      mem_req.wr_data = req_set_bits;
      // row writes beyond the memory are dropped
      if (req_take && (isx_pkg::opcode_type'(req_opcode) == isx_pkg::OP_WRITE_ROW) &&
          ({1'b0, req_node_index} < MaxCount)) begin
         mem_req.wr_en = 1'b1;
      end
   end

   isx_row_mem #(
      .DEPTH (MAX_NODES)
   ) u_row_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------------------------

   always_comb begin
      count_in = count_ff;
      lim_in   = lim_ff;
      if (csr_take) begin
         if (csr_node_count == '0) begin
            count_in = isx_pkg::CNT_W'(1);
         end else if (csr_node_count > MaxCount) begin
            count_in = MaxCount;
         end else begin
            count_in = csr_node_count;
         end
         lim_in = isx_pkg::limit_mask(count_in);
      end
   end

   // ---------------------------------------------------------------------------------------
   // request decode and issue
   // ---------------------------------------------------------------------------------------

   always_comb begin
      work_in = work_ff;
      set_in  = set_ff;
      cand_in = cand_ff;
      rd_in   = rd_ff;
      node_in = node_ff;
      last_in = last_ff;

      if (req_take) begin
         case (isx_pkg::opcode_type'(req_opcode))
            isx_pkg::OP_SEED: begin
               // a seed is a one-candidate expand of the empty set, unfiltered
               if ({1'b0, req_node_index} < count_ff) begin
                  work_in = isx_pkg::ROW_W'(1) << req_node_index;
               end
               set_in  = '0;
               cand_in = lim_ff;
            end
            isx_pkg::OP_EXPAND: begin
               work_in = req_candidate_bits & lim_ff;
               set_in  = req_set_bits & lim_ff;
               cand_in = req_candidate_bits & lim_ff;
            end
            default: begin
               // row writes go straight to memory, the spare code is dropped
            end
         endcase
      end

      if (issue) begin
         work_in = work_rest;
         node_in = pick_idx;
         last_in = (work_rest == '0);
         rd_in   = 1'b1;
      end else if (load) begin
         rd_in   = 1'b0;
      end
   end

   // ---------------------------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------------------------

   always_comb begin
      out_valid_in = out_valid_ff;
      out_set_in   = out_set_ff;
      out_cand_in  = out_cand_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_set_in   = set_ff | (isx_pkg::ROW_W'(1) << node_ff);
         out_cand_in  = cand_ff & rd_data & isx_pkg::above_mask(node_ff) & lim_ff;
         out_last_in  = last_ff;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_set        = out_set_ff;
   assign rsp_out_candidates = out_cand_ff;
   assign rsp_last           = out_last_ff;

   // ---------------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------------

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= MaxCount;
         lim_ff       <= isx_pkg::limit_mask(MaxCount);
         work_ff      <= '0;
         rd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lim_ff       <= lim_in;
         work_ff      <= work_in;
         rd_ff        <= rd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      cand_ff     <= cand_in;
      node_ff     <= node_in;
      last_ff     <= last_in;
      out_set_ff  <= out_set_in;
      out_cand_ff <= out_cand_in;
      out_last_ff <= out_last_in;
   end

`ifndef SYNTHESIS
   // a request is only taken with nothing left of the previous one in the read path
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rd_ff && (work_ff == '0)))
      else $error("request taken while candidates still pending");

   // every row read stays inside the configured node range
   assert property (@(posedge clock) disable iff (reset)
      rd_ff |-> ({1'b0, node_ff} < count_ff))
      else $error("row read beyond node count");

   // the read marked last leaves no candidate behind
   assert property (@(posedge clock) disable iff (reset)
      (rd_ff && last_ff) |-> (work_ff == '0))
      else $error("last result issued with candidates remaining");

   // effective count is always clamped
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= MaxCount))
      else $error("node count out of range");

   // a result taken by a stalled register would be lost
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_set_ff)))
      else $error("pending result overwritten");
`endif

endmodule

>>> sv/isx_row_mem.sv
// isx_row_mem: adjacency row store, one write and one read port, registered read data
// depends on isx_pkg for the access struct and widths
module isx_row_mem #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  isx_pkg::mem_req_type          mem_req,
   output logic [isx_pkg::ROW_W-1:0]     rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [isx_pkg::ROW_W-1:0] rows [DEPTH];
   logic [isx_pkg::ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         rows[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
   end

   // read data holds until the next read is issued
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= rows[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/isx_pick.sv
// isx_pick: picks the lowest pending candidate and the pending mask without it
// depends on isx_pkg for widths
module isx_pick (
   input  logic [isx_pkg::ROW_W-1:0] work,
   output logic [isx_pkg::IDX_W-1:0] pick_idx,
   output logic [isx_pkg::ROW_W-1:0] work_rest
);

   logic [isx_pkg::ROW_W-1:0] lowest;

   // isolate the lowest set bit
   assign lowest    = work & (~work + isx_pkg::ROW_W'(1));
   assign work_rest = work & ~lowest;

   // one-hot to binary, each position independent
   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < isx_pkg::ROW_W; i++) begin
         if (lowest[i]) begin
            pick_idx = pick_idx | isx_pkg::IDX_W'(i);
         end
      end
   end

endmodule

>>> tb/independent_set_expansion_unit_tb.sv
// independent_set_expansion_unit_tb: self-checking testbench for the independent set expansion unit
// depends on isx_pkg and independent_set_expansion_unit; predicts every grown set and checks it
`timescale 1ns / 1ps

module independent_set_expansion_unit_tb;

   localparam int NODES = 64;
   localparam int SETTLE_CYCLES = 12;        // settling wait in wait_idle after the last owed result is taken
   localparam int CYCLE_LIMIT = 10_000_000;  // worst case of 64 results per request, long stalls
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // one predicted result
   typedef struct packed {
      logic [isx_pkg::ROW_W-1:0] set_mask;
      logic [isx_pkg::ROW_W-1:0] cand_mask;
      logic                      is_last;
   } grown_set_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_opcode;
   logic [isx_pkg::IDX_W-1:0] req_node_index;
   logic [isx_pkg::ROW_W-1:0] req_set_bits;
   logic [isx_pkg::ROW_W-1:0] req_candidate_bits;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [isx_pkg::ROW_W-1:0] rsp_out_set;
   logic [isx_pkg::ROW_W-1:0] rsp_out_candidates;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [isx_pkg::CNT_W-1:0] csr_node_count;

   // shadow copy of the adjacency rows and the node count
   logic [isx_pkg::ROW_W-1:0] adj_rows [NODES];
   logic [isx_pkg::CNT_W-1:0] node_count_shadow;
   // grown sets still owed by the unit, and those of the most recent request
   grown_set_type             pending_sets[$];
   grown_set_type             latest_growth[$];
   int                        error_count = 0;
   int                        cycle_count = 0;
   bit                        idle_enable = 1'b1;

   independent_set_expansion_unit #(
      .MAX_NODES(NODES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_node_index     (req_node_index),
      .req_set_bits       (req_set_bits),
      .req_candidate_bits (req_candidate_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_set        (rsp_out_set),
      .rsp_out_candidates (rsp_out_candidates),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_node_count     (csr_node_count)
   );

   always #5 clock = ~clock;

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------- prediction

   // node count as the unit sees it: zero counts as one, above the maximum as the maximum
   function automatic int active_nodes();
      if (node_count_shadow == '0) return 1;
      if (node_count_shadow > isx_pkg::CNT_W'(NODES)) return NODES;
      return int'(node_count_shadow);
   endfunction

   // ones on the nodes in use
   function automatic logic [isx_pkg::ROW_W-1:0] in_range_mask();
      int cnt;
      cnt = active_nodes();
      if (cnt >= isx_pkg::ROW_W) return '1;
      return (isx_pkg::ROW_W'(1) << cnt) - isx_pkg::ROW_W'(1);
   endfunction

   // ones strictly above the node, none above the top node
   function automatic logic [isx_pkg::ROW_W-1:0] upper_mask(input int node);
      if (node >= isx_pkg::ROW_W - 1) return '0;
      return {isx_pkg::ROW_W{1'b1}} << (node + 1);
   endfunction

   // apply one accepted request to the shadow state and queue the grown sets it owes
   function automatic void grow_sets(input logic [1:0] op,
                                     input logic [isx_pkg::IDX_W-1:0] node,
                                     input logic [isx_pkg::ROW_W-1:0] set_in,
                                     input logic [isx_pkg::ROW_W-1:0] cand_in);
      logic [isx_pkg::ROW_W-1:0] lim;
      logic [isx_pkg::ROW_W-1:0] set_m;
      logic [isx_pkg::ROW_W-1:0] cand_m;
      grown_set_type             g;
      int                        top;
      int                        u;
      lim = in_range_mask();
      latest_growth.delete();
      if (op == isx_pkg::OP_WRITE_ROW) begin
         // stored unmasked, the mask applies on read
         adj_rows[node] = set_in;
      end else if (op == isx_pkg::OP_SEED) begin
         // a seed beyond the count gives nothing
         if (int'(node) < active_nodes()) begin
            g.set_mask  = isx_pkg::ROW_W'(1) << node;
            g.cand_mask = adj_rows[node] & upper_mask(int'(node)) & lim;
            g.is_last   = 1'b1;
            latest_growth = {latest_growth, g};
         end
      end else if (op == isx_pkg::OP_EXPAND) begin
         // masks cleared above the count, one grown set per candidate in ascending order
         set_m  = set_in & lim;
         cand_m = cand_in & lim;
         top = -1;
         for (u = 0; u < isx_pkg::ROW_W; u++) begin
            if (cand_m[u]) top = u;
         end
         for (u = 0; u < isx_pkg::ROW_W; u++) begin
            if (cand_m[u]) begin
               g.set_mask  = set_m | (isx_pkg::ROW_W'(1) << u);
               g.cand_mask = cand_m & adj_rows[u] & upper_mask(u) & lim;
               g.is_last   = (u == top);
               latest_growth = {latest_growth, g};
            end
         end
      end
      // unused opcode: nothing to do
      pending_sets = {pending_sets, latest_growth};
   endfunction

   // ---------------------------------------------------------------- checking

   // every result taken off the channel must match the oldest owed grown set
   always @(posedge clock) begin : result_check
      grown_set_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sets.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual set %h cand %h last %b",
                     $time, rsp_out_set, rsp_out_candidates, rsp_last);
         end else begin
            want = pending_sets.pop_front();
            if (rsp_out_set !== want.set_mask) begin
               error_count++;
               $display("%0t: out_set mismatch, expected %h actual %h",
                        $time, want.set_mask, rsp_out_set);
            end
            if (rsp_out_candidates !== want.cand_mask) begin
               error_count++;
               $display("%0t: out_candidates mismatch, expected %h actual %h",
                        $time, want.cand_mask, rsp_out_candidates);
            end
            if (rsp_last !== want.is_last) begin
               error_count++;
               $display("%0t: last mismatch, expected %b actual %b",
                        $time, want.is_last, rsp_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // mostly no gap, some short ones, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_enable || r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // masks of varied density
   function automatic logic [isx_pkg::ROW_W-1:0] random_mask();
      logic [isx_pkg::ROW_W-1:0] a;
      logic [isx_pkg::ROW_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: begin
            return a & b;
         end
         1: begin
            return a | b;
         end
         2: begin
            return a & b & {$urandom, $urandom};
         end
         default: begin
            return a;
         end
      endcase
   endfunction

   // result side back-pressure, stall periods always separated by a stretch without stall
   initial begin : stall_gen
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   // one request; valid stays high into the next request when there is no gap
   task automatic send_request(input logic [1:0] op, input logic [isx_pkg::IDX_W-1:0] node,
                               input logic [isx_pkg::ROW_W-1:0] set_in,
                               input logic [isx_pkg::ROW_W-1:0] cand_in);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         // idle with junk on the payload
         req_valid          <= 1'b0;
         req_opcode         <= 2'($urandom);
         req_node_index     <= isx_pkg::IDX_W'($urandom);
         req_set_bits       <= {$urandom, $urandom};
         req_candidate_bits <= {$urandom, $urandom};
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_node_index     <= node;
      req_set_bits       <= set_in;
      req_candidate_bits <= cand_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      grow_sets(op, node, set_in, cand_in);
   endtask

   // drop valid and let the unit drain fully
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_sets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [isx_pkg::CNT_W-1:0] value);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      node_count_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // every row written before anything reads one
   task automatic test_load_graph();
      int i;
      for (i = 0; i < NODES; i++) begin
         send_request(isx_pkg::OP_WRITE_ROW, isx_pkg::IDX_W'(i), random_mask(), random_mask());
      end
   endtask

   // field extremes, unused opcode, empty candidates, seeds beyond the count, count limits
   task automatic test_special_cases();
      send_request(isx_pkg::OP_WRITE_ROW, '0, '1, '1);
      send_request(isx_pkg::OP_SEED, '0, '0, '0);
      send_request(isx_pkg::OP_SEED, '1, '1, '1);
      // every node a candidate: 64 results
      send_request(isx_pkg::OP_EXPAND, '0, '0, '1);
      send_request(isx_pkg::OP_EXPAND, '1, '1, '0);
      send_request(isx_pkg::OP_EXPAND, isx_pkg::IDX_W'($urandom), random_mask(),
                   isx_pkg::ROW_W'(1) << (isx_pkg::ROW_W - 1));
      send_request(OP_UNUSED, isx_pkg::IDX_W'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom});
      send_request(isx_pkg::OP_WRITE_ROW, '1, '0, '0);
      send_request(isx_pkg::OP_EXPAND, '0, '0, {1'b1, {(isx_pkg::ROW_W - 2){1'b0}}, 1'b1});
      // zero counts as one node
      wait_idle();
      write_node_count('0);
      send_request(isx_pkg::OP_SEED, '0, '0, '0);
      send_request(isx_pkg::OP_SEED, isx_pkg::IDX_W'(1), '0, '0);
      send_request(isx_pkg::OP_EXPAND, '0, '1, '1);
      // above the maximum counts as the maximum
      wait_idle();
      write_node_count('1);
      send_request(isx_pkg::OP_SEED, '1, '0, '0);
      send_request(isx_pkg::OP_EXPAND, '0, random_mask(), random_mask());
      // small count: high mask bits cleared, seeds past the count silent
      wait_idle();
      write_node_count(isx_pkg::CNT_W'(5));
      send_request(isx_pkg::OP_SEED, isx_pkg::IDX_W'(4), '0, '0);
      send_request(isx_pkg::OP_SEED, isx_pkg::IDX_W'(5), '0, '0);
      send_request(isx_pkg::OP_SEED, '1, '0, '0);
      send_request(isx_pkg::OP_EXPAND, '0, '1, '1);
      send_request(isx_pkg::OP_EXPAND, '0, '1, ~isx_pkg::ROW_W'(31));
      send_request(isx_pkg::OP_WRITE_ROW, isx_pkg::IDX_W'(40), random_mask(), '0);
   endtask

   // unordered mix of every opcode with random content
   task automatic test_random_requests(input int count);
      int i;
      int r;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            send_request(isx_pkg::OP_WRITE_ROW, isx_pkg::IDX_W'($urandom), random_mask(),
                         random_mask());
         end else if (r < 40) begin
            send_request(isx_pkg::OP_SEED, isx_pkg::IDX_W'($urandom), random_mask(),
                         random_mask());
         end else if (r < 95) begin
            send_request(isx_pkg::OP_EXPAND, isx_pkg::IDX_W'($urandom), random_mask(),
                         random_mask());
         end else begin
            send_request(OP_UNUSED, isx_pkg::IDX_W'($urandom), random_mask(), random_mask());
         end
      end
   endtask

   // seed a node then keep expanding one of its grown sets, as enumeration would
   task automatic test_set_walks(input int walks);
      int                        w;
      int                        depth;
      grown_set_type             g;
      logic [isx_pkg::ROW_W-1:0] junk;
      for (w = 0; w < walks; w++) begin
         send_request(isx_pkg::OP_SEED, isx_pkg::IDX_W'($urandom_range(0, active_nodes() - 1)),
                      random_mask(), random_mask());
         for (depth = 0; depth < 5 && latest_growth.size() != 0; depth++) begin
            g = latest_growth[$urandom_range(0, latest_growth.size() - 1)];
            // occasionally break the chain with foreign candidates
            if ($urandom_range(0, 9) == 0) g.cand_mask = random_mask();
            // bits past the count must be ignored
            junk = random_mask() & ~in_range_mask();
            send_request(isx_pkg::OP_EXPAND, isx_pkg::IDX_W'($urandom), g.set_mask | junk,
                         g.cand_mask | (random_mask() & ~in_range_mask()));
         end
      end
   endtask

   // no gaps on either side
   task automatic test_back_to_back(input int count);
      idle_enable = 1'b0;
      test_random_requests(count);
      idle_enable = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_opcode         = '0;
      req_node_index     = '0;
      req_set_bits       = '0;
      req_candidate_bits = '0;
      csr_valid          = 1'b0;
      csr_node_count     = '0;
      node_count_shadow  = isx_pkg::CNT_W'(NODES);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset count of 64 in force until the first write
      test_load_graph();
      test_special_cases();

      wait_idle();
      write_node_count(isx_pkg::CNT_W'(NODES));
      test_random_requests(70);
      test_set_walks(20);

      wait_idle();
      write_node_count(isx_pkg::CNT_W'($urandom_range(2, 63)));
      test_random_requests(50);
      test_set_walks(12);

      wait_idle();
      write_node_count('1);
      test_back_to_back(40);

      wait_idle();
      write_node_count(isx_pkg::CNT_W'(1));
      test_random_requests(20);

      wait_idle();
      write_node_count(isx_pkg::CNT_W'($urandom_range(1, 127)));
      test_set_walks(8);

      wait_idle();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> independent_set_expansion_unit.f
sv/isx_pkg.sv
sv/isx_row_mem.sv
sv/isx_pick.sv
sv/independent_set_expansion_unit.sv
tb/independent_set_expansion_unit_tb.sv
